[rtl/rfsc_pkg.sv]
// ----------------------------------------------------------------------------
// rfsc_pkg
// shared constants and types of the rtu frame receiver with silence framing
// ----------------------------------------------------------------------------
package rfsc_pkg;

  localparam int MAX_FRAME_BYTES = 256;
  localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int MIN_FRAME       = 4;

  localparam logic [15:0] CRC_SEED      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] SILENCE_RESET = 16'd1750;
  localparam logic [15:0] QUIET_MAX     = 16'hFFFF;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic OP_BYTE      = 1'b0;
  localparam logic OP_TICK      = 1'b1;
  localparam logic KIND_ECHO    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    STATUS_VALID    = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_CRC      = 2'd2,
    STATUS_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] echo_byte;
    logic [7:0] byte_position;
    logic [8:0] frame_length;
    status_t    status;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/rfsc_front.sv]
// ----------------------------------------------------------------------------
// rfsc_front
// accepts bytes and ticks, keeps frame state and crc, builds result words
// ----------------------------------------------------------------------------
module rfsc_front import rfsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_data_byte,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  q_stat_t     q_stat,
  output logic        push,
  output result_t     push_word
);

  logic [15:0]      silence_r, silence_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [15:0]      quiet_r, quiet_nxt;
  logic             open_r, open_nxt;
  logic             ovf_r, ovf_nxt;

  logic             accept;
  logic             full_frame;
  logic [CNT_W-1:0] pos;
  logic [15:0]      limit;
  logic [15:0]      quiet_inc;
  logic [CNT_W+7:0] pos_ext;
  logic [CNT_W+8:0] len_ext;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  assign full_frame = ovf_r || (count_r >= CNT_W'(MAX_FRAME_BYTES));
  assign pos        = full_frame ? CNT_W'(MAX_FRAME_BYTES) : count_r;
  assign pos_ext    = {8'h00, pos};
  assign len_ext    = {9'h000, count_r};
  assign limit      = (silence_r == 16'd0) ? 16'd1 : silence_r;
  assign quiet_inc  = (quiet_r < QUIET_MAX) ? quiet_r + 16'd1 : quiet_r;

  always_comb begin
    silence_nxt = cfg_we ? cfg_data : silence_r;
    count_nxt   = count_r;
    crc_nxt     = crc_r;
    quiet_nxt   = quiet_r;
    open_nxt    = open_r;
    ovf_nxt     = ovf_r;
    push        = 1'b0;
    push_word   = '0;
    if (accept) begin
      if (in_operation == OP_BYTE) begin
        if (full_frame) begin
          ovf_nxt = 1'b1;
        end else begin
          crc_nxt   = crc_byte(crc_r, in_data_byte);
          count_nxt = count_r + CNT_W'(1);
        end
        open_nxt                = 1'b1;
        quiet_nxt               = 16'd0;
        push                    = 1'b1;
        push_word.kind          = KIND_ECHO;
        push_word.echo_byte     = in_data_byte;
        push_word.byte_position = (pos_ext > (CNT_W+8)'(255)) ? 8'hFF : pos_ext[7:0];
      end else if (open_r) begin
        quiet_nxt = quiet_inc;
        if (quiet_inc >= limit) begin
          push                   = 1'b1;
          push_word.kind         = KIND_VERDICT;
          push_word.frame_length = (len_ext > (CNT_W+9)'(511)) ? 9'h1FF : len_ext[8:0];
          if (ovf_r) begin
            push_word.status = STATUS_OVERFLOW;
          end else if (count_r < CNT_W'(MIN_FRAME)) begin
            push_word.status = STATUS_SHORT;
          end else if (crc_r != 16'd0) begin
            push_word.status = STATUS_CRC;
          end else begin
            push_word.status = STATUS_VALID;
          end
          count_nxt = '0;
          crc_nxt   = CRC_SEED;
          quiet_nxt = 16'd0;
          open_nxt  = 1'b0;
          ovf_nxt   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      silence_r <= SILENCE_RESET;
      count_r   <= '0;
      crc_r     <= CRC_SEED;
      quiet_r   <= 16'd0;
      open_r    <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      silence_r <= silence_nxt;
      count_r   <= count_nxt;
      crc_r     <= crc_nxt;
      quiet_r   <= quiet_nxt;
      open_r    <= open_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

endmodule

[rtl/rfsc_queue.sv]
// ----------------------------------------------------------------------------
// rfsc_queue
// short register queue of result words between front and back
// ----------------------------------------------------------------------------
module rfsc_queue import rfsc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_word,
  input  logic    pop,
  output result_t pop_word,
  output q_stat_t q_stat
);

  result_t         mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   fill_r, fill_nxt;
  logic            do_push;
  logic            do_pop;

  assign q_stat.full  = (fill_r == (Q_AW+1)'(Q_DEPTH));
  assign q_stat.empty = (fill_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_word     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    fill_nxt   = fill_r + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

[rtl/rfsc_back.sv]
// ----------------------------------------------------------------------------
// rfsc_back
// output register stage, drains the queue into the result channel
// ----------------------------------------------------------------------------
module rfsc_back import rfsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  q_stat_t    q_stat,
  input  result_t    pop_word,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_echo_byte,
  output logic [7:0] out_byte_position,
  output logic [8:0] out_frame_length,
  output logic [1:0] out_status
);

  logic    valid_r, valid_nxt;
  result_t word_r;
  logic    load;

  assign load      = !valid_r || !out_stall;
  assign pop       = load && !q_stat.empty;
  assign valid_nxt = load ? !q_stat.empty : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      word_r <= pop_word;
    end
  end

  assign out_valid         = valid_r;
  assign out_kind          = word_r.kind;
  assign out_echo_byte     = word_r.echo_byte;
  assign out_byte_position = word_r.byte_position;
  assign out_frame_length  = word_r.frame_length;
  assign out_status        = word_r.status;

endmodule

[rtl/rtu_frame_silence_crc_checker.sv]
// ----------------------------------------------------------------------------
// rtu_frame_silence_crc_checker
// rtu byte receiver with silence framing and crc-16 frame check
// ----------------------------------------------------------------------------
// Takes one word per clock: a received byte or one timebase tick. Each byte
// gives an echo word with its frame position; when silence_ticks ticks pass
// after the last byte, one verdict word gives length and status. The crc
// update is combinational in the front, so a word is accepted every cycle
// while the four-word result queue has room; in_stall rises only when that
// queue is full, which happens only under out_stall. Results leave through a
// registered output stage. cfg_ready is always high; write silence_ticks
// only while idle.
module rtu_frame_silence_crc_checker import rfsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_echo_byte,
  output logic [7:0]  out_byte_position,
  output logic [8:0]  out_frame_length,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  q_stat_t q_stat;
  logic    push;
  result_t push_word;
  logic    pop;
  result_t pop_word;

  assign cfg_ready = 1'b1;

  rfsc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_data_byte (in_data_byte),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .q_stat       (q_stat),
    .push         (push),
    .push_word    (push_word)
  );

  rfsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .q_stat    (q_stat)
  );

  rfsc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .pop_word          (pop_word),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_echo_byte     (out_echo_byte),
    .out_byte_position (out_byte_position),
    .out_frame_length  (out_frame_length),
    .out_status        (out_status)
  );

endmodule

[rtl/rfsc_checker.sv]
// ----------------------------------------------------------------------------
// rfsc_checker
// port-level checks of the rtu frame receiver, bound to the top level
// ----------------------------------------------------------------------------
module rfsc_checker import rfsc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_kind,
  input logic [7:0] out_echo_byte,
  input logic [7:0] out_byte_position,
  input logic [8:0] out_frame_length,
  input logic [1:0] out_status
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(out_echo_byte) && $stable(out_byte_position) &&
      $stable(out_frame_length) && $stable(out_status))
    else $error("stalled result word changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_echo_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ECHO |-> out_frame_length == 9'd0 &&
      out_status == STATUS_VALID)
    else $error("echo word carries verdict fields");

  a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_VERDICT && out_status == STATUS_SHORT |->
      out_frame_length < 9'(MIN_FRAME) && out_echo_byte == 8'd0 &&
      out_byte_position == 8'd0)
    else $error("too-short verdict with long frame");

  a_valid_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_VERDICT &&
      (out_status == STATUS_VALID || out_status == STATUS_CRC) |->
      out_frame_length >= 9'(MIN_FRAME))
    else $error("crc-checked verdict on short frame");

endmodule

bind rtu_frame_silence_crc_checker rfsc_checker u_rfsc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_kind          (out_kind),
  .out_echo_byte     (out_echo_byte),
  .out_byte_position (out_byte_position),
  .out_frame_length  (out_frame_length),
  .out_status        (out_status)
);
